// ----- rtl/aef_pkg.sv -----
package aef_pkg;

  localparam int GAIN_W = 16;
  localparam int GAIN_FRAC = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int POS_W = 32;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [63:0] EXP_A_Q32 = 64'd25681630549;
  localparam logic [63:0] EXP_B_Q32 = 64'd25685203658;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] GAIN_ONE = 64'd32768;

  localparam logic [31:0] ROOT_Q30 [16] = '{
    32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
    32'd1097253708, 32'd1085434106, 32'd1079572135, 32'd1076653033,
    32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
    32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FADE_DIRECTION = 2'd0,
    CFG_WINDOW_START   = 2'd1,
    CFG_WINDOW_LENGTH  = 2'd2,
    CFG_PHASE_STEP     = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    REGION_BEFORE = 2'd0,
    REGION_INSIDE = 2'd1,
    REGION_AFTER  = 2'd2
  } region_e;

  typedef struct packed {
    region_e region;
    logic    mute;
  } ctl_t;

  // Gain table entry k: 2^(k*A/2^table_bits - B) in Q1.15, rounded, capped at one.
  function automatic logic [GAIN_W-1:0] gain_entry(input int k, input int table_bits);
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] q;
    logic [31:0] r;
    logic [31:0] f;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] g;
    t = (64'(k) * EXP_A_Q32) >> table_bits;
    m = EXP_B_Q32 - t;
    q = m >> 32;
    r = m[31:0];
    p = ONE_Q30;
    if (r == 32'd0) begin
      s = q + 64'd15;
    end else begin
      f = (~r) + 32'd1;
      for (int i = 0; i < 16; i++) begin
        if (f[31-i]) begin
          p = (p * {32'd0, ROOT_Q30[i]}) >> 30;
        end
      end
      s = q + 64'd16;
    end
    g = (p + (64'd1 << (s - 64'd1))) >> s;
    if (g > GAIN_ONE) begin
      g = GAIN_ONE;
    end
    return g[GAIN_W-1:0];
  endfunction

endpackage

// ----- rtl/audio_exponential_fader_core.sv -----
// Channel   Direction  Handshake            Payload
// input     in         push_i / full_o      sample_in_i, buffer_first_i
// result    out        pop_i / empty_o      sample_out_o, region_o
// config    in         cfg_we_i             cfg_index_i, cfg_data_i
//
// One word is accepted and one result leaves per cycle while results are popped
// and no queue is full. A word passes the input queue, the gain table read, the
// interpolation multiply, the gain sum and the sample multiply to the result port.
// Reset clears the position, the phase and all configuration registers at once.
// full_o rises when the four-word queue behind the front holds four words; the back
// stops drawing from it once the result queue and its four stages hold eight words.
module audio_exponential_fader_core #(
  parameter int GAIN_TABLE_BITS = 8,
  parameter int PHASE_BITS      = 24,
  parameter int SAMPLE_BITS     = 16,
  localparam int CfgDataW       = (PHASE_BITS + 1 > 32) ? PHASE_BITS + 1 : 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aef_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]             cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  logic                            buffer_first_i,
  input  logic                            pop_i,
  output logic                            empty_o,
  output logic signed [SAMPLE_BITS-1:0]   sample_out_o,
  output logic [1:0]                      region_o
);

  localparam int CtlW  = $bits(aef_pkg::ctl_t);
  localparam int MidW  = SAMPLE_BITS + PHASE_BITS + 1 + CtlW;
  localparam int OutW  = SAMPLE_BITS + 2;
  localparam int MidCW = $clog2(aef_pkg::MID_DEPTH + 1);
  localparam int OutCW = $clog2(aef_pkg::OUT_DEPTH + 1);

  logic                   accept;
  logic [PHASE_BITS:0]    front_phase;
  aef_pkg::ctl_t          front_ctl;
  logic [MidW-1:0]        mid_wdata, mid_rdata;
  logic                   mid_empty, mid_pop;
  logic [MidCW-1:0]       mid_count;
  logic [SAMPLE_BITS-1:0] mid_sample;
  logic [PHASE_BITS:0]    mid_phase;
  aef_pkg::ctl_t          mid_ctl;
  logic                   out_push, out_full;
  logic [OutCW-1:0]       out_count;
  logic [SAMPLE_BITS-1:0] back_sample;
  aef_pkg::region_e       back_region;
  logic [OutW-1:0]        out_rdata;

  assign accept = push_i && !full_o;

  aef_front #(
    .PHASE_BITS (PHASE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CFG_DATA_W (CfgDataW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .buffer_first_i(buffer_first_i),
    .phase_o       (front_phase),
    .ctl_o         (front_ctl)
  );

  assign mid_wdata = {sample_in_i, front_phase, front_ctl};

  aef_fifo #(
    .WIDTH(MidW),
    .DEPTH(aef_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (mid_wdata),
    .pop_i  (mid_pop),
    .data_o (mid_rdata),
    .full_o (full_o),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  assign {mid_sample, mid_phase, mid_ctl} = mid_rdata;

  aef_back #(
    .GAIN_TABLE_BITS(GAIN_TABLE_BITS),
    .PHASE_BITS     (PHASE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_sample_i(mid_sample),
    .mid_phase_i (mid_phase),
    .mid_ctl_i   (mid_ctl),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_sample_o(back_sample),
    .out_region_o(back_region)
  );

  aef_fifo #(
    .WIDTH(OutW),
    .DEPTH(aef_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i ({back_sample, back_region}),
    .pop_i  (pop_i),
    .data_o (out_rdata),
    .full_o (out_full),
    .empty_o(empty_o),
    .count_o(out_count)
  );

  assign sample_out_o = out_rdata[OutW-1:2];
  assign region_o     = out_rdata[1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("result word written into a full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   mid_count == '0 |-> mid_empty && !mid_pop)
    else $error("back drew a word from an empty queue");

endmodule

// ----- rtl/aef_fifo.sv -----
module aef_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(DEPTH))
    else $error("queue count exceeds its depth");

endmodule

// ----- rtl/aef_front.sv -----
module aef_front #(
  parameter int PHASE_BITS  = 24,
  parameter int SAMPLE_BITS = 16,
  parameter int CFG_DATA_W  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [aef_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         accept_i,
  input  logic                         buffer_first_i,
  output logic [PHASE_BITS:0]          phase_o,
  output aef_pkg::ctl_t                ctl_o
);

  localparam int PosW = aef_pkg::POS_W;
  localparam logic [PHASE_BITS:0] One = {1'b1, {PHASE_BITS{1'b0}}};

  logic                fade_dir_q;
  logic [PosW-1:0]     win_start_q;
  logic [PosW-1:0]     win_len_q;
  logic [PHASE_BITS:0] step_q;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PHASE_BITS:0] phase_q, phase_d;

  logic [PosW-1:0]     pos;
  logic [PosW-1:0]     offset;
  logic                before_win;
  logic                in_win;
  logic [PHASE_BITS:0] x;
  logic [PHASE_BITS+1:0] nx;

  always_comb begin
    pos        = buffer_first_i ? '0 : pos_q;
    offset     = pos - win_start_q;
    before_win = (pos < win_start_q);
    in_win     = !before_win && (offset < win_len_q);
    x          = (pos == win_start_q) ? '0 : phase_q;
    nx         = {1'b0, x} + {1'b0, step_q};
    pos_d      = (pos == {PosW{1'b1}}) ? pos : pos + PosW'(1);
    phase_d    = phase_q;
    if (in_win) begin
      phase_d = (nx > {1'b0, One}) ? One : nx[PHASE_BITS:0];
    end
  end

  always_comb begin
    phase_o     = fade_dir_q ? (One - x) : x;
    ctl_o.mute  = fade_dir_q;
    if (before_win) begin
      ctl_o.region = aef_pkg::REGION_BEFORE;
    end else if (in_win) begin
      ctl_o.region = aef_pkg::REGION_INSIDE;
    end else begin
      ctl_o.region = aef_pkg::REGION_AFTER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_dir_q  <= 1'b0;
      win_start_q <= '0;
      win_len_q   <= '0;
      step_q      <= '0;
    end else if (cfg_we_i) begin
      case (aef_pkg::cfg_index_e'(cfg_index_i))
        aef_pkg::CFG_FADE_DIRECTION: fade_dir_q  <= cfg_data_i[0];
        aef_pkg::CFG_WINDOW_START:   win_start_q <= cfg_data_i[PosW-1:0];
        aef_pkg::CFG_WINDOW_LENGTH:  win_len_q   <= cfg_data_i[PosW-1:0];
        aef_pkg::CFG_PHASE_STEP:     step_q      <= cfg_data_i[PHASE_BITS:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q <= One)
    else $error("fade phase has passed unity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept_i && buffer_first_i |=> pos_q == PosW'(1))
    else $error("first word of a buffer did not restart the position");

endmodule

// ----- rtl/aef_back.sv -----
module aef_back #(
  parameter int GAIN_TABLE_BITS = 8,
  parameter int PHASE_BITS      = 24,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               mid_empty_i,
  input  logic [SAMPLE_BITS-1:0]             mid_sample_i,
  input  logic [PHASE_BITS:0]                mid_phase_i,
  input  aef_pkg::ctl_t                      mid_ctl_i,
  output logic                               mid_pop_o,
  input  logic [$clog2(aef_pkg::OUT_DEPTH+1)-1:0] out_count_i,
  output logic                               out_push_o,
  output logic [SAMPLE_BITS-1:0]             out_sample_o,
  output aef_pkg::region_e                   out_region_o
);

  localparam int GainW     = aef_pkg::GAIN_W;
  localparam int TableSize = (1 << GAIN_TABLE_BITS) + 1;
  localparam int IdxW      = GAIN_TABLE_BITS + 1;
  localparam int Sh        = PHASE_BITS - GAIN_TABLE_BITS;
  localparam int FracW     = (Sh > 0) ? Sh : 1;
  localparam int CntW      = $clog2(aef_pkg::OUT_DEPTH + 1);
  localparam int OccW      = CntW + 1;
  localparam logic [PHASE_BITS:0] FracMask = (PHASE_BITS+1)'((64'd1 << Sh) - 64'd1);

  logic [GainW-1:0] rom [TableSize];

  for (genvar k = 0; k < TableSize; k++) begin : g_rom
    localparam logic [GainW-1:0] Entry = aef_pkg::gain_entry(k, GAIN_TABLE_BITS);
    assign rom[k] = Entry;
  end

  logic v1_q, v2_q, v3_q, v4_q;

  logic [SAMPLE_BITS-1:0] s1_sample_q, s2_sample_q, s3_sample_q, s4_sample_q;
  aef_pkg::ctl_t          s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q;
  logic [GainW-1:0]       s1_lo_q, s1_hi_q, s2_lo_q, s3_gain_q;
  logic [FracW-1:0]       s1_frac_q;
  logic [GainW+FracW-1:0] s2_prod_q;
  logic [SAMPLE_BITS-1:0] s3_mag_q;
  logic                   s3_neg_q, s4_neg_q;
  logic [SAMPLE_BITS+GainW-1:0] s4_prod_q;

  logic [IdxW-1:0]        lo_idx, hi_idx;
  logic [PHASE_BITS:0]    frac_full;
  logic [GainW-1:0]       diff;
  logic [GainW+FracW-1:0] interp;
  logic                   neg2;
  logic [OccW-1:0]        occupancy;
  logic [SAMPLE_BITS+GainW-1:0] scaled_full;
  logic [SAMPLE_BITS-1:0] scaled;

  assign occupancy = OccW'(out_count_i) + OccW'(v1_q) + OccW'(v2_q) + OccW'(v3_q)
                   + OccW'(v4_q);
  assign mid_pop_o = !mid_empty_i && (occupancy < OccW'(aef_pkg::OUT_DEPTH));

  always_comb begin
    frac_full = mid_phase_i & FracMask;
    if (mid_phase_i[PHASE_BITS]) begin
      lo_idx = IdxW'(TableSize - 1);
      hi_idx = IdxW'(TableSize - 1);
    end else begin
      lo_idx = IdxW'(mid_phase_i[PHASE_BITS-1:0] >> Sh);
      hi_idx = lo_idx + IdxW'(1);
    end
    diff   = (s1_hi_q < s1_lo_q) ? '0 : s1_hi_q - s1_lo_q;
    interp = s2_prod_q >> Sh;
    neg2   = s2_sample_q[SAMPLE_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= mid_pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sample_q <= mid_sample_i;
    s1_ctl_q    <= mid_ctl_i;
    s1_lo_q     <= rom[lo_idx];
    s1_hi_q     <= rom[hi_idx];
    s1_frac_q   <= mid_phase_i[PHASE_BITS] ? '0 : frac_full[FracW-1:0];

    s2_sample_q <= s1_sample_q;
    s2_ctl_q    <= s1_ctl_q;
    s2_lo_q     <= s1_lo_q;
    s2_prod_q   <= diff * s1_frac_q;

    s3_sample_q <= s2_sample_q;
    s3_ctl_q    <= s2_ctl_q;
    s3_gain_q   <= s2_lo_q + interp[GainW-1:0];
    s3_neg_q    <= neg2;
    s3_mag_q    <= neg2 ? ('0 - s2_sample_q) : s2_sample_q;

    s4_sample_q <= s3_sample_q;
    s4_ctl_q    <= s3_ctl_q;
    s4_neg_q    <= s3_neg_q;
    s4_prod_q   <= s3_mag_q * s3_gain_q;
  end

  always_comb begin
    scaled_full  = s4_prod_q >> aef_pkg::GAIN_FRAC;
    scaled       = scaled_full[SAMPLE_BITS-1:0];
    out_push_o   = v4_q;
    out_region_o = s4_ctl_q.region;
    case (s4_ctl_q.region)
      aef_pkg::REGION_INSIDE: out_sample_o = s4_neg_q ? ('0 - scaled) : scaled;
      aef_pkg::REGION_AFTER:  out_sample_o = s4_ctl_q.mute ? '0 : s4_sample_q;
      default:                out_sample_o = s4_sample_q;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   occupancy <= OccW'(aef_pkg::OUT_DEPTH))
    else $error("result queue credit overrun");

endmodule

// ----- tb/sv/audio_exponential_fader_core_tb.sv -----
module audio_exponential_fader_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aef_pkg::*;

  localparam logic [24:0] PHASE_ONE = 25'h100_0000;
  localparam logic [63:0] LOG_SLOPE_Q32 = 64'd25681630549;
  localparam logic [63:0] LOG_OFFSET_Q32 = 64'd25685203658;
  localparam logic [63:0] UNITY_Q30 = 64'd1073741824;
  localparam logic [31:0] HALVING_ROOTS_Q30 [16] = '{
    32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
    32'd1097253708, 32'd1085434106, 32'd1079572135, 32'd1076653033,
    32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
    32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
  };

  typedef struct packed {
    logic [15:0] sample;
    region_e     region;
  } fader_word_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_WORD,
    ROW_WORD_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_index_e  reg_idx;
    logic [31:0] value;
    logic [15:0] sample;
    logic        first;
    logic [15:0] want_sample;
    region_e     want_region;
  } plan_row_t;

  localparam int PLAN_ROWS = 38;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b1, 16'h7fff, REGION_AFTER},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h8000, REGION_AFTER},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h0000, 1'b0, 16'h0000, REGION_AFTER},
    '{ROW_WRITE, CFG_FADE_DIRECTION, 32'd1, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_START, 32'd2, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'd3, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_PHASE_STEP, 32'h0100_0000, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'd1234, 1'b1, 16'd1234, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'hffff, 1'b0, 16'hffff, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'd555, 1'b0, 16'h0000, REGION_AFTER},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h0000, REGION_AFTER},
    '{ROW_WRITE, CFG_FADE_DIRECTION, 32'd0, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_START, 32'd0, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'd0, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b1, 16'h8000, REGION_AFTER},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'd7, 1'b0, 16'd7, REGION_AFTER},
    '{ROW_WRITE, CFG_WINDOW_START, 32'd1, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'd4, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_PHASE_STEP, 32'h0055_5555, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'd100, 1'b1, 16'd100, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'hffff, 1'b1, 16'hffff, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_START, 32'd0, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_LENGTH, 32'hffff_ffff, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_PHASE_STEP, 32'h0100_0000, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b1, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD, CFG_FADE_DIRECTION, 32'd0, 16'h0001, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WRITE, CFG_WINDOW_START, 32'hffff_ffff, 16'h0, 1'b0, 16'h0, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h7fff, 1'b1, 16'h7fff, REGION_BEFORE},
    '{ROW_WORD_KNOWN, CFG_FADE_DIRECTION, 32'd0, 16'h8000, 1'b0, 16'h8000, REGION_BEFORE}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        push_i;
  logic        full_o;
  logic [15:0] sample_in_i;
  logic        buffer_first_i;
  logic        pop_i;
  logic        empty_o;
  logic [15:0] sample_out_o;
  logic [1:0]  region_o;

  logic [15:0] gain_tab [257];
  logic        fading_down;
  logic [31:0] win_start;
  logic [31:0] win_len;
  logic [24:0] phase_inc;
  logic [31:0] next_pos;
  logic [24:0] cur_phase;

  fader_word_t pending_out [$];
  int          mismatches;
  int          words_checked;
  int          reg_writes;
  int          send_idle_pct;
  int          recv_stall_pct;

  audio_exponential_fader_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .sample_in_i    (sample_in_i),
    .buffer_first_i (buffer_first_i),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .sample_out_o   (sample_out_o),
    .region_o       (region_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [15:0] gain_interp(input logic [24:0] x);
    logic [63:0] lo;
    logic [63:0] hi;
    if (x[24]) begin
      return gain_tab[256];
    end
    lo = 64'(gain_tab[x[23:16]]);
    hi = 64'(gain_tab[x[23:16] + 9'd1]);
    if (hi < lo) begin
      return lo[15:0];
    end
    return 16'(lo + (((hi - lo) * 64'(x[15:0])) >> 16));
  endfunction

  function automatic fader_word_t fade_word(input logic [15:0] raw, input logic first);
    fader_word_t res;
    logic [31:0] pos;
    logic [24:0] x;
    logic [25:0] nx;
    logic [16:0] mag;
    logic [63:0] scaled;
    logic [15:0] gain;
    pos = first ? 32'd0 : next_pos;
    next_pos = (pos == 32'hffff_ffff) ? pos : pos + 32'd1;
    res.sample = raw;
    if (pos < win_start) begin
      res.region = REGION_BEFORE;
    end else if (pos - win_start < win_len) begin
      x = (pos == win_start) ? 25'd0 : cur_phase;
      if (x > PHASE_ONE) begin
        x = PHASE_ONE;
      end
      nx = {1'b0, x} + {1'b0, phase_inc};
      cur_phase = (nx > {1'b0, PHASE_ONE}) ? PHASE_ONE : nx[24:0];
      gain = gain_interp(fading_down ? PHASE_ONE - x : x);
      mag = raw[15] ? 17'h1_0000 - {1'b0, raw} : {1'b0, raw};
      scaled = (64'(mag) * 64'(gain)) >> 15;
      res.sample = raw[15] ? 16'd0 - scaled[15:0] : scaled[15:0];
      res.region = REGION_INSIDE;
    end else begin
      res.region = REGION_AFTER;
      if (fading_down) begin
        res.sample = '0;
      end
    end
    return res;
  endfunction

  task automatic send_word(input logic [15:0] raw, input logic first, input logic known,
                           input fader_word_t known_word);
    fader_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push_i <= 1'b0;
    end
    @(negedge clk_i);
    push_i <= 1'b1;
    sample_in_i <= raw;
    buffer_first_i <= first;
    do begin
      @(posedge clk_i);
    end while (full_o !== 1'b0);
    predicted = fade_word(raw, first);
    pending_out.push_back(known ? known_word : predicted);
  endtask

  task automatic settle();
    @(negedge clk_i);
    push_i <= 1'b0;
    while (pending_out.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_FADE_DIRECTION: fading_down = value[0];
      CFG_WINDOW_START:   win_start = value;
      CFG_WINDOW_LENGTH:  win_len = value;
      CFG_PHASE_STEP:     phase_inc = value[24:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    pop_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    fader_word_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_out.size() == 0) begin
        flag_mismatch($sformatf("word %0d in region %0d with nothing expected",
                                $signed(sample_out_o), region_o));
      end else begin
        want = pending_out.pop_front();
        words_checked++;
        if (sample_out_o !== want.sample) begin
          flag_mismatch($sformatf("sample %0d, expected %0d", $signed(sample_out_o),
                                  $signed(want.sample)));
        end
        if (region_o !== want.region) begin
          flag_mismatch($sformatf("region %0d, expected %0d", region_o, want.region));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] g;
    logic [63:0] sh;
    logic [31:0] f;
    logic [31:0] start_pick;
    logic [31:0] len_pick;
    logic [31:0] step_pick;
    logic [15:0] raw;
    logic        first;
    int          buf_left;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_FADE_DIRECTION;
    cfg_data_i = '0;
    push_i = 1'b0;
    sample_in_i = '0;
    buffer_first_i = 1'b0;
    pop_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    words_checked = 0;
    reg_writes = 0;
    fading_down = 1'b0;
    win_start = '0;
    win_len = '0;
    phase_inc = '0;
    next_pos = '0;
    cur_phase = '0;

    for (int k = 0; k < 257; k++) begin
      t = (64'(k) * LOG_SLOPE_Q32) >> 8;
      m = LOG_OFFSET_Q32 - t;
      p = UNITY_Q30;
      sh = (m >> 32) + 64'd15;
      if (m[31:0] != 32'd0) begin
        f = 32'(64'h1_0000_0000 - 64'(m[31:0]));
        for (int i = 0; i < 16; i++) begin
          if (f[31-i]) begin
            p = (p * 64'(HALVING_ROOTS_Q30[i])) >> 30;
          end
        end
        sh = sh + 64'd1;
      end
      g = (p + (64'd1 << (sh - 64'd1))) >> sh;
      gain_tab[k] = (g > 64'd32768) ? 16'h8000 : g[15:0];
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        settle();
        write_reg(PLAN[r].reg_idx, PLAN[r].value);
      end else begin
        send_word(PLAN[r].sample, PLAN[r].first, PLAN[r].kind == ROW_WORD_KNOWN,
                  '{PLAN[r].want_sample, PLAN[r].want_region});
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        start_pick = ($urandom_range(7) == 0) ? 32'hffff_ffff : $urandom_range(0, 24);
        case ($urandom_range(7))
          0: len_pick = 32'd0;
          1: len_pick = 32'hffff_ffff;
          default: len_pick = $urandom_range(1, 48);
        endcase
        case ($urandom_range(3))
          0: step_pick = 32'd0;
          1: step_pick = 32'h0100_0000;
          2: step_pick = (len_pick != 0) ? 32'h0100_0000 / len_pick : 32'd0;
          default: step_pick = $urandom_range(0, 32'h0100_0000);
        endcase
        write_reg(CFG_FADE_DIRECTION, $urandom_range(1));
        write_reg(CFG_WINDOW_START, start_pick);
        write_reg(CFG_WINDOW_LENGTH, len_pick);
        write_reg(CFG_PHASE_STEP, step_pick);
        buf_left = 0;
        for (int n = 0; n < 50; n++) begin
          if (seg == 1 && n == 25) begin
            settle();
          end
          if (buf_left == 0) begin
            first = 1'b1;
            buf_left = $urandom_range(1, 80);
          end else begin
            first = ($urandom_range(15) == 0);
          end
          buf_left--;
          case ($urandom_range(11))
            0: raw = 16'h7fff;
            1: raw = 16'h8000;
            2: raw = 16'hffff;
            default: raw = 16'($urandom_range(0, 65535));
          endcase
          send_word(raw, first, 1'b0, '0);
        end
      end
    end

    settle();
    $display("checked %0d output words after %0d register writes,", words_checked, reg_writes);
    $display("covering fade in and out, empty and open windows, and four flow patterns");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
